// ===== sv/dnap_pkg.sv =====
package dnap_pkg;

  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_PART_START = 2'd1;
  localparam logic [1:0] PH_AFTER_ZERO = 2'd2;
  localparam logic [1:0] PH_DIGITS     = 2'd3;

  localparam logic [1:0] RX_DEC = 2'd0;
  localparam logic [1:0] RX_OCT = 2'd1;
  localparam logic [1:0] RX_HEX = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_CHAR   = 3'd1;
  localparam logic [2:0] ST_MANY_PARTS = 3'd2;
  localparam logic [2:0] ST_AREA_RANGE = 3'd3;
  localparam logic [2:0] ST_NODE_RANGE = 3'd4;

  localparam logic CFG_AREA_LIMIT = 1'b0;
  localparam logic CFG_NODE_LIMIT = 1'b1;

  localparam logic [5:0] AREA_LIMIT_RESET = 6'd63;
  localparam logic [9:0] NODE_LIMIT_RESET = 10'd1023;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_F   = 8'h66;
  localparam logic [7:0] CH_LO_X   = 8'h78;

  typedef struct packed {
    logic        emit;
    logic [2:0]  status;
    logic [15:0] address;
  } step_res_t;

endpackage

// ===== sv/dnap_step.sv =====
module dnap_step #(
  parameter int ACC_WIDTH = 32,
  parameter int OFF_LIMIT = 255
) (
  input  logic [7:0]           char_code,
  input  logic                 first_char,
  input  logic [1:0]           phase,
  input  logic [1:0]           radix,
  input  logic [ACC_WIDTH-1:0] acc,
  input  logic [15:0]          first_part,
  input  logic                 parts_seen,
  input  logic [7:0]           char_offset,
  input  logic [5:0]           area_limit,
  input  logic [9:0]           node_limit,
  output logic [1:0]           phase_nxt,
  output logic [1:0]           radix_nxt,
  output logic [ACC_WIDTH-1:0] acc_nxt,
  output logic [15:0]          first_part_nxt,
  output logic                 parts_seen_nxt,
  output logic [7:0]           char_offset_nxt,
  output dnap_pkg::step_res_t  res
);

  localparam logic [7:0] OFF_MAX = 8'(OFF_LIMIT);

  logic                 active;
  logic                 consumed;
  logic                 is_x;
  logic                 dig_ok;
  logic [3:0]           dig;
  logic                 is_stop;
  logic [ACC_WIDTH-1:0] acc_scaled;
  logic [15:0]          part;

  always_comb begin
    phase_nxt       = phase;
    radix_nxt       = radix;
    acc_nxt         = acc;
    first_part_nxt  = first_part;
    parts_seen_nxt  = parts_seen;
    char_offset_nxt = char_offset;
    res             = '0;
    active          = 1'b1;
    consumed        = 1'b0;
    dig_ok          = 1'b0;
    dig             = '0;
    acc_scaled      = '0;
    part            = '0;

    is_x    = (char_code == dnap_pkg::CH_LO_X) || (char_code == dnap_pkg::CH_UP_X);
    is_stop = (char_code == dnap_pkg::CH_NUL) || (char_code == dnap_pkg::CH_SPACE) ||
              ((char_code >= dnap_pkg::CH_TAB) && (char_code <= dnap_pkg::CH_CR));

    if (first_char) begin
      phase_nxt       = dnap_pkg::PH_PART_START;
      radix_nxt       = dnap_pkg::RX_DEC;
      acc_nxt         = '0;
      first_part_nxt  = '0;
      parts_seen_nxt  = 1'b0;
      char_offset_nxt = '0;
    end else if (phase == dnap_pkg::PH_IDLE) begin
      active = 1'b0;
    end else if (char_offset < OFF_MAX) begin
      char_offset_nxt = char_offset + 8'd1;
    end

    if (active) begin
      if (phase_nxt == dnap_pkg::PH_PART_START) begin
        if (char_code == dnap_pkg::CH_ZERO) begin
          radix_nxt = dnap_pkg::RX_OCT;
          phase_nxt = dnap_pkg::PH_AFTER_ZERO;
          consumed  = 1'b1;
        end else begin
          radix_nxt = dnap_pkg::RX_DEC;
          phase_nxt = dnap_pkg::PH_DIGITS;
          if (is_x) begin
            radix_nxt = dnap_pkg::RX_HEX;
            consumed  = 1'b1;
          end
        end
      end else if (phase_nxt == dnap_pkg::PH_AFTER_ZERO) begin
        phase_nxt = dnap_pkg::PH_DIGITS;
        if (is_x) begin
          radix_nxt = dnap_pkg::RX_HEX;
          consumed  = 1'b1;
        end
      end

      if ((char_code >= dnap_pkg::CH_ZERO) && (char_code <= dnap_pkg::CH_NINE)) begin
        dig_ok = 1'b1;
        dig    = 4'(char_code - dnap_pkg::CH_ZERO);
      end else if (radix_nxt == dnap_pkg::RX_HEX) begin
        if ((char_code >= dnap_pkg::CH_LO_A) && (char_code <= dnap_pkg::CH_LO_F)) begin
          dig_ok = 1'b1;
          dig    = 4'(char_code - dnap_pkg::CH_LO_A + 8'd10);
        end else if ((char_code >= dnap_pkg::CH_UP_A) && (char_code <= dnap_pkg::CH_UP_F)) begin
          dig_ok = 1'b1;
          dig    = 4'(char_code - dnap_pkg::CH_UP_A + 8'd10);
        end
      end

      case (radix_nxt)
        dnap_pkg::RX_HEX: acc_scaled = acc_nxt << 4;
        dnap_pkg::RX_OCT: acc_scaled = acc_nxt << 3;
        default:          acc_scaled = (acc_nxt << 3) + (acc_nxt << 1);
      endcase

      part = acc_nxt[15:0];

      if (!consumed) begin
        if (dig_ok) begin
          acc_nxt = acc_scaled + {{(ACC_WIDTH-4){1'b0}}, dig};
        end else if (char_code == dnap_pkg::CH_DOT) begin
          if (parts_seen_nxt) begin
            res.emit   = 1'b1;
            res.status = dnap_pkg::ST_MANY_PARTS;
          end else begin
            first_part_nxt = part;
            parts_seen_nxt = 1'b1;
            acc_nxt        = '0;
            radix_nxt      = dnap_pkg::RX_DEC;
            phase_nxt      = dnap_pkg::PH_PART_START;
          end
        end else begin
          res.emit = 1'b1;
          if (!is_stop) begin
            res.status = dnap_pkg::ST_BAD_CHAR;
          end else if (!parts_seen_nxt) begin
            if ((part == 16'd0) || (part > {10'd0, area_limit})) begin
              res.status = dnap_pkg::ST_AREA_RANGE;
            end else begin
              res.status  = dnap_pkg::ST_OK;
              res.address = part;
            end
          end else if ((first_part_nxt == 16'd0) ||
                       (first_part_nxt > {10'd0, area_limit})) begin
            res.status = dnap_pkg::ST_AREA_RANGE;
          end else if ((part == 16'd0) || (part > {6'd0, node_limit})) begin
            res.status = dnap_pkg::ST_NODE_RANGE;
          end else begin
            res.status  = dnap_pkg::ST_OK;
            res.address = {first_part_nxt[5:0], part[9:0]};
          end
        end
      end

      if (res.emit) begin
        phase_nxt = dnap_pkg::PH_IDLE;
      end
    end
  end

endmodule

// ===== sv/decnet_address_text_parser_core.sv =====
// path: an accepted stop character is held in the input register, then the parse step
// writes its result word into the result register
// throughput: one character per cycle, one parse step each, when output not stalled
// reset: synchronous active-low rst_n clears the parse state to idle, empties both
// registers and sets area_limit to 63 and node_limit to 1023
module decnet_address_text_parser_core #(
  parameter int MAX_LEN   = 255,
  parameter int ACC_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // char_code[7:0]
  input  logic [0:0]  in_tuser,   // first_char[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // address[15:0], stop_offset[23:16]
  output logic [2:0]  out_tuser,  // status[2:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int OFF_LIMIT = (MAX_LEN < 255) ? MAX_LEN : 255;

  logic                 in_valid_r;
  logic [7:0]           in_char_r;
  logic                 in_first_r;
  logic                 proc_fire;

  logic [5:0]           area_limit_r;
  logic [9:0]           node_limit_r;

  logic [1:0]           phase_r, phase_nxt;
  logic [1:0]           radix_r, radix_nxt;
  logic [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic [15:0]          first_part_r, first_part_nxt;
  logic                 parts_seen_r, parts_seen_nxt;
  logic [7:0]           char_offset_r, char_offset_nxt;
  dnap_pkg::step_res_t  res;

  logic                 out_valid_r;
  logic [2:0]           out_status_r;
  logic [15:0]          out_addr_r;
  logic [7:0]           out_off_r;

  assign proc_fire = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || proc_fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r  <= in_tdata;
      in_first_r <= in_tuser[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_limit_r <= dnap_pkg::AREA_LIMIT_RESET;
      node_limit_r <= dnap_pkg::NODE_LIMIT_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index[0])
        dnap_pkg::CFG_AREA_LIMIT: area_limit_r <= cfg_data[5:0];
        dnap_pkg::CFG_NODE_LIMIT: node_limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dnap_step #(
    .ACC_WIDTH (ACC_WIDTH),
    .OFF_LIMIT (OFF_LIMIT)
  ) u_step (
    .char_code       (in_char_r),
    .first_char      (in_first_r),
    .phase           (phase_r),
    .radix           (radix_r),
    .acc             (acc_r),
    .first_part      (first_part_r),
    .parts_seen      (parts_seen_r),
    .char_offset     (char_offset_r),
    .area_limit      (area_limit_r),
    .node_limit      (node_limit_r),
    .phase_nxt       (phase_nxt),
    .radix_nxt       (radix_nxt),
    .acc_nxt         (acc_nxt),
    .first_part_nxt  (first_part_nxt),
    .parts_seen_nxt  (parts_seen_nxt),
    .char_offset_nxt (char_offset_nxt),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= dnap_pkg::PH_IDLE;
      radix_r       <= dnap_pkg::RX_DEC;
      acc_r         <= '0;
      first_part_r  <= '0;
      parts_seen_r  <= 1'b0;
      char_offset_r <= '0;
    end else if (proc_fire) begin
      phase_r       <= phase_nxt;
      radix_r       <= radix_nxt;
      acc_r         <= acc_nxt;
      first_part_r  <= first_part_nxt;
      parts_seen_r  <= parts_seen_nxt;
      char_offset_r <= char_offset_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res.emit) begin
      out_status_r <= res.status;
      out_addr_r   <= res.address;
      out_off_r    <= char_offset_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_off_r, out_addr_r};
  assign out_tuser  = out_status_r;

endmodule

// ===== sv/dnap_checker.sv =====
module dnap_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= dnap_pkg::ST_NODE_RANGE)
    else $error("undefined status on result word");

  a_err_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != dnap_pkg::ST_OK |-> out_tdata[15:0] == 16'd0)
    else $error("nonzero address with error status");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind decnet_address_text_parser_core dnap_checker u_dnap_checker (.*);

// ===== tb/sv/decnet_address_text_parser_core_tb.sv =====
module decnet_address_text_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] OFFSET_MAX = 8'd255;

  typedef struct packed {
    logic [7:0] code;
    logic       first;
  } char_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] address;
    logic [7:0]  offset;
  } addr_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [0:0]  in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = 1'b0;
  logic [9:0]  cfg_data = 10'd0;

  decnet_address_text_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser state as the block should hold it
  logic [1:0]  parse_phase = dnap_pkg::PH_IDLE;
  logic [1:0]  parse_radix = dnap_pkg::RX_DEC;
  logic [31:0] parse_acc = '0;
  logic [15:0] area_value = '0;
  logic [1:0]  parts_seen = '0;
  logic [7:0]  char_pos = '0;
  logic [5:0]  area_lim = dnap_pkg::AREA_LIMIT_RESET;
  logic [9:0]  node_lim = dnap_pkg::NODE_LIMIT_RESET;

  char_word_t   char_queue[$];
  addr_result_t expected_addrs[$];
  int           words_queued = 0;
  int           chars_queued = 0;
  int           chars_seen = 0;
  int           fail_count = 0;

  int burst_left = 0;
  int gap_left = 0;
  int mode_left = 0;
  int stall_mode = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  function automatic void flag_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endfunction

  function automatic int digit_of(logic [7:0] c, logic [1:0] rx);
    if (c >= dnap_pkg::CH_ZERO && c <= dnap_pkg::CH_NINE) return int'(c - dnap_pkg::CH_ZERO);
    if (rx == dnap_pkg::RX_HEX) begin
      if (c >= dnap_pkg::CH_LO_A && c <= dnap_pkg::CH_LO_F)
        return int'(c - dnap_pkg::CH_LO_A) + 10;
      if (c >= dnap_pkg::CH_UP_A && c <= dnap_pkg::CH_UP_F)
        return int'(c - dnap_pkg::CH_UP_A) + 10;
    end
    return -1;
  endfunction

  function automatic bit within_limit(logic [15:0] v, logic [9:0] lim);
    return v >= 16'd1 && v <= 16'(lim);
  endfunction

  // one character into the parser; returns 1 when an address word is due
  function automatic bit parse_char(input logic [7:0] c, input logic first,
                                    output addr_result_t res);
    int          dv;
    logic [31:0] base;
    logic [15:0] part;
    res = '0;
    if (first) begin
      parse_phase = dnap_pkg::PH_PART_START;
      parse_radix = dnap_pkg::RX_DEC;
      parse_acc = '0;
      area_value = '0;
      parts_seen = '0;
      char_pos = '0;
    end else if (parse_phase == dnap_pkg::PH_IDLE) begin
      return 1'b0;
    end else if (char_pos != OFFSET_MAX) begin
      char_pos = char_pos + 8'd1;
    end

    if (parse_phase == dnap_pkg::PH_PART_START) begin
      if (c == dnap_pkg::CH_ZERO) begin
        parse_radix = dnap_pkg::RX_OCT;
        parse_phase = dnap_pkg::PH_AFTER_ZERO;
        return 1'b0;
      end
      parse_radix = dnap_pkg::RX_DEC;
      parse_phase = dnap_pkg::PH_DIGITS;
      if (c == dnap_pkg::CH_LO_X || c == dnap_pkg::CH_UP_X) begin
        parse_radix = dnap_pkg::RX_HEX;
        return 1'b0;
      end
    end else if (parse_phase == dnap_pkg::PH_AFTER_ZERO) begin
      parse_phase = dnap_pkg::PH_DIGITS;
      if (c == dnap_pkg::CH_LO_X || c == dnap_pkg::CH_UP_X) begin
        parse_radix = dnap_pkg::RX_HEX;
        return 1'b0;
      end
    end

    dv = digit_of(c, parse_radix);
    if (dv >= 0) begin
      base = (parse_radix == dnap_pkg::RX_HEX) ? 32'd16 :
             (parse_radix == dnap_pkg::RX_OCT) ? 32'd8 : 32'd10;
      parse_acc = parse_acc * base + 32'(dv);
      return 1'b0;
    end

    res.offset = char_pos;
    parse_phase = dnap_pkg::PH_IDLE;
    if (c == dnap_pkg::CH_DOT) begin
      if (parts_seen != 2'd0) begin
        res.status = dnap_pkg::ST_MANY_PARTS;
        return 1'b1;
      end
      area_value = parse_acc[15:0];
      parts_seen = 2'd1;
      parse_acc = '0;
      parse_radix = dnap_pkg::RX_DEC;
      parse_phase = dnap_pkg::PH_PART_START;
      return 1'b0;
    end

    part = parse_acc[15:0];
    if (!(c == dnap_pkg::CH_NUL || c == dnap_pkg::CH_SPACE ||
          (c >= dnap_pkg::CH_TAB && c <= dnap_pkg::CH_CR))) begin
      res.status = dnap_pkg::ST_BAD_CHAR;
    end else if (parts_seen == 2'd0) begin
      if (!within_limit(part, 10'(area_lim))) res.status = dnap_pkg::ST_AREA_RANGE;
      else res.address = part;
    end else if (!within_limit(area_value, 10'(area_lim))) begin
      res.status = dnap_pkg::ST_AREA_RANGE;
    end else if (!within_limit(part, node_lim)) begin
      res.status = dnap_pkg::ST_NODE_RANGE;
    end else begin
      res.address = {area_value[5:0], part[9:0]};
    end
    return 1'b1;
  endfunction

  // sender: bursts of words with random gaps
  always @(posedge clk) begin
    logic       send;
    char_word_t w;
    send = 1'b0;
    w = '0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (char_queue.size() != 0) begin
        w = char_queue.pop_front();
        send = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
      in_tvalid <= send;
      if (send) begin
        in_tdata <= w.code;
        in_tuser <= w.first;
      end
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off
  always @(posedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!long_hold_done && chars_seen >= 300) begin
        hold_left = 400;
        long_hold_done = 1'b1;
        rdy = 1'b0;
      end else begin
        case (stall_mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = $urandom_range(0, 1);
          default: rdy = ($urandom_range(0, 7) == 0);
        endcase
      end
      out_tready <= rdy;
    end
  end

  // monitor: predict on accepted characters, check accepted address words
  always @(posedge clk) begin
    addr_result_t want;
    addr_result_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        chars_seen <= chars_seen + 1;
        if (parse_char(in_tdata, in_tuser[0], want)) expected_addrs.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.status = out_tuser;
        got.address = out_tdata[15:0];
        got.offset = out_tdata[23:16];
        if (expected_addrs.size() == 0) begin
          flag_failure($sformatf("unexpected word: status %0d address %h offset %0d",
                                 got.status, got.address, got.offset));
        end else begin
          want = expected_addrs.pop_front();
          if (got.status !== want.status || got.address !== want.address ||
              got.offset !== want.offset)
            flag_failure($sformatf(
              "word mismatch: expected status %0d address %h offset %0d, got %0d %h %0d",
              want.status, want.address, want.offset, got.status, got.address, got.offset));
        end
      end
    end
  end

  task automatic push_word(logic [7:0] code, logic first);
    char_queue.push_back('{code: code, first: first});
    words_queued++;
    chars_queued++;
  endtask

  task automatic push_text(string s, bit add_stop, logic [7:0] stop_code = dnap_pkg::CH_NUL);
    for (int i = 0; i < s.len(); i++) push_word(s[i], i == 0);
    if (add_stop) push_word(stop_code, s.len() == 0);
  endtask

  function automatic logic [31:0] pick_value(logic [9:0] lim);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'(lim);
      3: return 32'(lim) + 32'd1;
      4: return ($urandom_range(1, 3) << 16) | 32'(lim);
      5: return $urandom_range(0, 65535);
      6: return $urandom();
      default: return $urandom_range(1, 32'(lim));
    endcase
  endfunction

  function automatic string render_part(logic [31:0] v);
    string s;
    int    form;
    form = $urandom_range(0, 9);
    s = "";
    if (form == 0) return s;
    if (form <= 4) begin
      s = $sformatf("%0d", v);
    end else if (form <= 6) begin
      s = $sformatf("0%0o", v);
    end else if (form <= 8) begin
      s = $sformatf("%0h", v);
      for (int i = 0; i < s.len(); i++)
        if (s[i] >= dnap_pkg::CH_LO_A && $urandom_range(0, 1)) s[i] = s[i] - 8'd32;
      case ($urandom_range(0, 3))
        0: s = {"0x", s};
        1: s = {"0X", s};
        2: s = {"x", s};
        default: s = {"X", s};
      endcase
    end else begin
      // long decimal run so the accumulator can wrap
      s = $sformatf("%0d", $urandom_range(1, 9));
      repeat ($urandom_range(9, 13)) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    end
    return s;
  endfunction

  task automatic push_address();
    string      s;
    int         kind;
    logic [7:0] stop_code;
    bit         odd_stop;
    s = render_part(pick_value(10'(area_lim)));
    kind = $urandom_range(0, 9);
    if (kind >= 3) s = {s, ".", render_part(pick_value(node_lim))};
    if (kind == 9) s = {s, ".", render_part(pick_value(node_lim))};
    odd_stop = 1'b0;
    case ($urandom_range(0, 9))
      0: stop_code = dnap_pkg::CH_SPACE;
      1, 2: stop_code = 8'($urandom_range(dnap_pkg::CH_TAB, dnap_pkg::CH_CR));
      3: begin
        stop_code = 8'($urandom_range(1, 255));
        odd_stop = 1'b1;
      end
      default: stop_code = dnap_pkg::CH_NUL;
    endcase
    push_text(s, 1'b1, stop_code);
    if (odd_stop) push_word(dnap_pkg::CH_NUL, 1'b0);
  endtask

  task automatic push_random_text();
    string s;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 74) begin
      push_address();
    end else if (pick < 84) begin
      // well-formed text with one character replaced
      s = {render_part(pick_value(10'(area_lim))), ".", render_part(pick_value(node_lim))};
      s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(1, 255));
      push_text(s, 1'b1, dnap_pkg::CH_NUL);
    end else if (pick < 92) begin
      // cut short, the next text restarts the parse
      s = {render_part(pick_value(10'(area_lim))), ".", render_part(pick_value(node_lim))};
      push_text(s.substr(0, $urandom_range(1, s.len()) - 1), 1'b0);
    end else begin
      repeat ($urandom_range(1, 4)) begin
        char_queue.push_back('{code: 8'($urandom_range(0, 255)), first: 1'b0});
        words_queued++;
      end
    end
  endtask

  task automatic wait_drained();
    while (chars_seen != words_queued || expected_addrs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(input logic [0:0] idx, input logic [9:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == dnap_pkg::CFG_AREA_LIMIT) area_lim = value[5:0];
    else node_lim = value;
  endtask

  initial begin
    string s;
    int    drain_cycles;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // idle stream word, ignored
    char_queue.push_back('{code: dnap_pkg::CH_NINE, first: 1'b0});
    words_queued++;
    push_text("1", 1'b1, dnap_pkg::CH_NUL);
    push_text("077.x3ff", 1'b1, dnap_pkg::CH_SPACE);
    push_text("1.2.", 1'b0);
    push_text("9z", 1'b0);
    push_text(".5", 1'b1, dnap_pkg::CH_CR);
    push_text("12", 1'b0);
    push_text("3", 1'b1, dnap_pkg::CH_TAB);
    push_text("1.0", 1'b1, dnap_pkg::CH_NUL);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1: begin
          write_limit(dnap_pkg::CFG_AREA_LIMIT, 10'd1);
          write_limit(dnap_pkg::CFG_NODE_LIMIT, 10'd1);
        end
        2: begin
          write_limit(dnap_pkg::CFG_AREA_LIMIT, 10'(dnap_pkg::AREA_LIMIT_RESET));
          write_limit(dnap_pkg::CFG_NODE_LIMIT, dnap_pkg::NODE_LIMIT_RESET);
        end
        3, 4: begin
          write_limit(dnap_pkg::CFG_AREA_LIMIT, 10'($urandom_range(1, 63)));
          write_limit(dnap_pkg::CFG_NODE_LIMIT, 10'($urandom_range(1, 1023)));
        end
        default: ;
      endcase
      if (ph == 2) begin
        // offset saturation on a long text
        s = "";
        repeat ($urandom_range(260, 300)) s = {s, "0"};
        push_text({s, "5"}, 1'b1, dnap_pkg::CH_NUL);
      end
      while (chars_queued < (ph + 1) * 305 + 25) push_random_text();
      wait_drained();
    end

    drain_cycles = 0;
    while ((chars_seen != words_queued || expected_addrs.size() != 0) && drain_cycles < 20000)
    begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (20) @(posedge clk);
    if (expected_addrs.size() != 0)
      flag_failure($sformatf("%0d address words never arrived", expected_addrs.size()));
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
